FILE: rtl/promotable_priority_table_defines.svh
// Assertion macros for the promotable priority table.
`ifndef PROMOTABLE_PRIORITY_TABLE_DEFINES_SVH
`define PROMOTABLE_PRIORITY_TABLE_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define PPT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppt: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define PPT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppt: next-cycle check failed");

`endif

FILE: rtl/ppt_pkg.sv
package ppt_pkg;

    localparam int OP_W     = 3;
    localparam int STATUS_W = 3;

    // Operation codes of an input word
    typedef enum logic [OP_W-1:0] {
        OP_ADD      = 3'd0,
        OP_QUERY    = 3'd1,
        OP_PROMOTE  = 3'd2,
        OP_PEEK_MAX = 3'd3,
        OP_POP_MAX  = 3'd4
    } op_t;

    // Status codes of a result word
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK     = 3'd0,
        STATUS_EMPTY  = 3'd1,
        STATUS_FULL   = 3'd2,
        STATUS_BADID  = 3'd3,
        STATUS_NOTAGS = 3'd4
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH,
        S_READ,
        S_CHECK
    } state_t;

endpackage

FILE: rtl/ppt_if.sv
// Command channel: one word per operation
interface ppt_cmd_if #(
    parameter int SLOT_W  = 4,
    parameter int TAG_W   = 32,
    parameter int VALUE_W = 32
);
    import ppt_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [SLOT_W-1:0]  entry_slot;
    logic [TAG_W-1:0]   entry_tag;
    logic [VALUE_W-1:0] new_value;

    modport source (output valid, output operation, output entry_slot,
                    output entry_tag, output new_value, input ready);
    modport sink (input valid, input operation, input entry_slot,
                  input entry_tag, input new_value, output ready);
endinterface

// Result channel: one word per recognised operation
interface ppt_res_if #(
    parameter int SLOT_W  = 4,
    parameter int TAG_W   = 32,
    parameter int VALUE_W = 32,
    parameter int PRIO_W  = 16
);
    import ppt_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                is_live;
    logic [SLOT_W-1:0]   out_slot;
    logic [TAG_W-1:0]    out_tag;
    logic [VALUE_W-1:0]  out_value;
    logic [PRIO_W-1:0]   out_priority;

    modport source (output valid, output status, output is_live, output out_slot,
                    output out_tag, output out_value, output out_priority,
                    input ready);
    modport sink (input valid, input status, input is_live, input out_slot,
                  input out_tag, input out_value, input out_priority,
                  output ready);
endinterface

FILE: rtl/promotable_priority_table.sv
// Channel | Role   | Word carries
// cmd     | sink   | operation, entry_slot, entry_tag, new_value
// rsp     | source | status, is_live, out_slot, out_tag, out_value, out_priority
//
// Add, peek_max and pop_max scan every slot: one entry read per cycle from the
// entry RAM through one (priority, tag) comparator. Query and promote read one entry.
// After reset a clearing pass marks every entry free; cmd.ready stays low.
// cmd.ready is high only while the sequencer is idle; the result register frees the
// sequencer, and a finished item waits in its last state while rsp is stalled.
// Unknown operation codes are taken and dropped without a result.
`include "promotable_priority_table_defines.svh"

module promotable_priority_table #(
    parameter int SLOTS          = 16,
    parameter int VALUE_WIDTH    = 32,
    parameter int PRIORITY_WIDTH = 16,
    parameter int TAG_WIDTH      = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    ppt_cmd_if.sink   cmd,
    ppt_res_if.source rsp
);
    import ppt_pkg::*;

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int ENTRY_W = 1 + TAG_WIDTH + PRIORITY_WIDTH + VALUE_WIDTH;
    // Entry layout: {live, tag, priority, value}
    localparam int LIVE_BIT = ENTRY_W - 1;
    localparam int TAG_LO   = PRIORITY_WIDTH + VALUE_WIDTH;
    localparam int PRIO_LO  = VALUE_WIDTH;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
    localparam logic [SLOT_W:0]   SLOT_LIMIT = (SLOT_W + 1)'(SLOTS);

    state_t state_reg, state_next;

    logic [SLOT_W-1:0] clr_idx_reg, clr_idx_next;
    logic [SLOT_W-1:0] scan_idx_reg, scan_idx_next;
    logic              eval_valid_reg, eval_valid_next;
    logic [SLOT_W-1:0] eval_idx_reg, eval_idx_next;
    logic [TAG_WIDTH:0] next_tag_reg, next_tag_next;

    // Latched command word
    op_t                    op_reg, op_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic [TAG_WIDTH-1:0]   tag_reg, tag_next;
    logic [VALUE_WIDTH-1:0] value_reg, value_next;

    // Scan trackers
    logic                      best_found_reg, best_found_next;
    logic [SLOT_W-1:0]         best_slot_reg, best_slot_next;
    logic [TAG_WIDTH-1:0]      best_tag_reg, best_tag_next;
    logic [PRIORITY_WIDTH-1:0] best_prio_reg, best_prio_next;
    logic [VALUE_WIDTH-1:0]    best_value_reg, best_value_next;
    logic                      free_found_reg, free_found_next;
    logic [SLOT_W-1:0]         free_slot_reg, free_slot_next;

    // Result register
    logic                      rsp_valid_reg, rsp_valid_next;
    status_t                   rsp_status_reg, rsp_status_next;
    logic                      rsp_live_reg, rsp_live_next;
    logic [SLOT_W-1:0]         rsp_slot_reg, rsp_slot_next;
    logic [TAG_WIDTH-1:0]      rsp_tag_reg, rsp_tag_next;
    logic [VALUE_WIDTH-1:0]    rsp_value_reg, rsp_value_next;
    logic [PRIORITY_WIDTH-1:0] rsp_prio_reg, rsp_prio_next;

    // Entry RAM ports
    logic               wr_en;
    logic [SLOT_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    logic [SLOT_W-1:0]  rd_addr;
    logic [ENTRY_W-1:0] rd_data;

    logic                      e_live;
    logic [TAG_WIDTH-1:0]      e_tag;
    logic [PRIORITY_WIDTH-1:0] e_prio;
    logic [VALUE_WIDTH-1:0]    e_value;
    logic [PRIORITY_WIDTH-1:0] e_prio_inc;
    logic                      better;
    logic                      slot_ok;
    logic                      hit;
    logic                      out_free;
    logic                      accept;

    ppt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Unpack the entry just read
    assign e_live  = rd_data[LIVE_BIT];
    assign e_tag   = rd_data[LIVE_BIT-1:TAG_LO];
    assign e_prio  = rd_data[TAG_LO-1:PRIO_LO];
    assign e_value = rd_data[VALUE_WIDTH-1:0];

    // Shared comparator: higher priority wins, and on equal priority the newer (higher tag) entry wins
    assign better = !best_found_reg ||
                    ({e_prio, e_tag} > {best_prio_reg, best_tag_reg});

    assign e_prio_inc = (e_prio == {PRIORITY_WIDTH{1'b1}}) ? e_prio
                                                           : e_prio + 1'b1;
    assign slot_ok  = ({1'b0, slot_reg} < SLOT_LIMIT);
    assign hit      = slot_ok && e_live && (e_tag == tag_reg);
    assign out_free = !rsp_valid_reg || rsp.ready;
    assign accept   = cmd.valid && cmd.ready;

    assign cmd.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.is_live      = rsp_live_reg;
    assign rsp.out_slot     = rsp_slot_reg;
    assign rsp.out_tag      = rsp_tag_reg;
    assign rsp.out_value    = rsp_value_reg;
    assign rsp.out_priority = rsp_prio_reg;

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_idx_reg    <= '0;
            scan_idx_reg   <= '0;
            eval_valid_reg <= 1'b0;
            next_tag_reg   <= '0;
            best_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_idx_reg    <= clr_idx_next;
            scan_idx_reg   <= scan_idx_next;
            eval_valid_reg <= eval_valid_next;
            next_tag_reg   <= next_tag_next;
            best_found_reg <= best_found_next;
            free_found_reg <= free_found_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        eval_idx_reg   <= eval_idx_next;
        op_reg         <= op_next;
        slot_reg       <= slot_next;
        tag_reg        <= tag_next;
        value_reg      <= value_next;
        best_slot_reg  <= best_slot_next;
        best_tag_reg   <= best_tag_next;
        best_prio_reg  <= best_prio_next;
        best_value_reg <= best_value_next;
        free_slot_reg  <= free_slot_next;
        rsp_status_reg <= rsp_status_next;
        rsp_live_reg   <= rsp_live_next;
        rsp_slot_reg   <= rsp_slot_next;
        rsp_tag_reg    <= rsp_tag_next;
        rsp_value_reg  <= rsp_value_next;
        rsp_prio_reg   <= rsp_prio_next;
    end

    // Sequencer: next state, RAM control and result load
    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        scan_idx_next   = scan_idx_reg;
        eval_valid_next = 1'b0;
        eval_idx_next   = scan_idx_reg;
        next_tag_next   = next_tag_reg;
        op_next         = op_reg;
        slot_next       = slot_reg;
        tag_next        = tag_reg;
        value_next      = value_reg;
        best_found_next = best_found_reg;
        best_slot_next  = best_slot_reg;
        best_tag_next   = best_tag_reg;
        best_prio_next  = best_prio_reg;
        best_value_next = best_value_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_live_next   = rsp_live_reg;
        rsp_slot_next   = rsp_slot_reg;
        rsp_tag_next    = rsp_tag_reg;
        rsp_value_next  = rsp_value_reg;
        rsp_prio_next   = rsp_prio_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = '0;
        rd_en           = 1'b0;
        rd_addr         = scan_idx_reg;

        // Fold the entry read last cycle into the scan trackers
        if (eval_valid_reg)
        begin
            if (e_live && better)
            begin
                best_found_next = 1'b1;
                best_slot_next  = eval_idx_reg;
                best_tag_next   = e_tag;
                best_prio_next  = e_prio;
                best_value_next = e_value;
            end
            if (!e_live && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_slot_next  = eval_idx_reg;
            end
        end

        case (state_reg)
            S_CLEAR:
            begin
                // Mark every entry free, one per cycle
                wr_en        = 1'b1;
                wr_addr      = clr_idx_reg;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_SLOT)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = op_t'(cmd.operation);
                    slot_next       = cmd.entry_slot;
                    tag_next        = cmd.entry_tag;
                    value_next      = cmd.new_value;
                    scan_idx_next   = '0;
                    best_found_next = 1'b0;
                    free_found_next = 1'b0;
                    case (op_t'(cmd.operation))
                        OP_ADD, OP_PEEK_MAX, OP_POP_MAX: state_next = S_SCAN;
                        OP_QUERY, OP_PROMOTE:            state_next = S_READ;
                        default:                         state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN:
            begin
                // Issue one entry read per cycle
                rd_en           = 1'b1;
                rd_addr         = scan_idx_reg;
                eval_valid_next = 1'b1;
                scan_idx_next   = scan_idx_reg + 1'b1;
                if (scan_idx_reg == LAST_SLOT)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // Commit the add or pop and load the result when the output is free
                if (out_free)
                begin
                    state_next      = S_IDLE;
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = STATUS_OK;
                    rsp_live_next   = 1'b0;
                    rsp_slot_next   = '0;
                    rsp_tag_next    = '0;
                    rsp_value_next  = '0;
                    rsp_prio_next   = '0;
                    if (op_reg == OP_ADD)
                    begin
                        if (!free_found_reg)
                        begin
                            rsp_status_next = STATUS_FULL;
                        end
                        else if (next_tag_reg[TAG_WIDTH])
                        begin
                            rsp_status_next = STATUS_NOTAGS;
                        end
                        else
                        begin
                            wr_en         = 1'b1;
                            wr_addr       = free_slot_reg;
                            wr_data       = {1'b1, next_tag_reg[TAG_WIDTH-1:0],
                                             {PRIORITY_WIDTH{1'b0}}, value_reg};
                            next_tag_next = next_tag_reg + 1'b1;
                            rsp_slot_next = free_slot_reg;
                            rsp_tag_next  = next_tag_reg[TAG_WIDTH-1:0];
                        end
                    end
                    else if (!best_found_reg)
                    begin
                        rsp_status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        rsp_live_next  = 1'b1;
                        rsp_slot_next  = best_slot_reg;
                        rsp_tag_next   = best_tag_reg;
                        rsp_value_next = best_value_reg;
                        rsp_prio_next  = best_prio_reg;
                        if (op_reg == OP_POP_MAX)
                        begin
                            wr_en   = 1'b1;
                            wr_addr = best_slot_reg;
                        end
                    end
                end
            end
            S_READ:
            begin
                rd_en      = slot_ok;
                rd_addr    = slot_reg;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                // Answer query or promote from the entry read
                if (out_free)
                begin
                    state_next      = S_IDLE;
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = STATUS_OK;
                    rsp_live_next   = 1'b0;
                    rsp_slot_next   = '0;
                    rsp_tag_next    = '0;
                    rsp_value_next  = '0;
                    rsp_prio_next   = '0;
                    if (hit)
                    begin
                        rsp_live_next  = 1'b1;
                        rsp_slot_next  = slot_reg;
                        rsp_tag_next   = e_tag;
                        rsp_value_next = e_value;
                        rsp_prio_next  = e_prio;
                        if (op_reg == OP_PROMOTE)
                        begin
                            wr_en         = 1'b1;
                            wr_addr       = slot_reg;
                            wr_data       = {1'b1, e_tag, e_prio_inc, e_value};
                            rsp_prio_next = e_prio_inc;
                        end
                    end
                    else if (op_reg == OP_PROMOTE)
                    begin
                        rsp_status_next = STATUS_BADID;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Checks
    `PPT_ASSERT_NEXT(a_tag_never_falls, clk, rst_n, 1'b1, next_tag_reg >= $past(next_tag_reg))
    `PPT_ASSERT_SAME(a_no_write_on_accept, clk, rst_n, wr_en, !accept)
    `PPT_ASSERT_SAME(a_idle_no_read_in_flight, clk, rst_n, state_reg == S_IDLE, !eval_valid_reg)

endmodule

FILE: rtl/ppt_ram.sv
module ppt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
